/* rtl/sise_pkg.sv */
// Package for the sorted id set engine: operation and status codes,
// request and result payload structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sise_pkg;

  localparam int unsigned IdBits = 31;
  localparam int unsigned OutHandleBits = 16;
  localparam int unsigned CountBits = 8;

  typedef enum logic [2:0] {
    OP_LOOKUP = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_POP    = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]               operation;
    logic [IdBits-1:0]        key_id;
    logic [OutHandleBits-1:0] entry_handle;
  } req_t;

  typedef struct packed {
    logic                     found;
    logic [IdBits-1:0]        result_id;
    logic [OutHandleBits-1:0] result_handle;
    logic [1:0]               status;
    logic [CountBits-1:0]     entry_count;
    logic                     is_empty;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // capture request
    logic scan;     // advance scan index
    logic to_top;   // set index to count (start of insert shift)
    logic peek_dn;  // read entry idx-1
    logic peek_up;  // read entry idx+1
    logic shift_up; // move entry idx-1 to idx (insert)
    logic shift_dn; // move entry idx+1 to idx (drop)
    logic write_new;
    logic clear;
    logic respond;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_end;   // index reached count
    logic id_hit;     // current entry id equals key
    logic id_greater; // current entry id exceeds key
    logic hnd_hit;    // current entry handle equals request handle
    logic full;
    logic empty;
    logic at_bottom;  // shift index reached 0
    logic drop_end;   // drop index reached count-1
  } stat_t;

endpackage
`default_nettype wire

/* rtl/sise_ram.sv */
// Generic RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sise_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* rtl/sise_datapath.sv */
// Datapath of the sorted id set engine: id and handle memories, count,
// scan index and result register. Depends on sise_pkg and sise_ram.
`timescale 1ns / 1ps
`default_nettype none
module sise_datapath import sise_pkg::*; #(
  parameter int unsigned Capacity   = 128,
  parameter int unsigned HandleBits = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire req_t                  req_i,
  input  wire cmd_t                  cmd_i,
  input  wire logic                  rd_valid_i, // memory data is for idx
  input  wire logic [1:0]            rsp_kind_i, // 0 none, 1 entry, 2 full
  input  wire logic                  rsp_found_i,
  input  wire logic                  rsp_miss_i,
  output stat_t                      stat_o,
  output rsp_t                       rsp_o
);
  localparam int unsigned AddrBits = $clog2(Capacity);
  localparam int unsigned CntBits  = $clog2(Capacity + 1);

  logic [2:0]            op_q;
  logic [IdBits-1:0]     key_q;
  logic [HandleBits-1:0] hnd_q;
  logic [CntBits-1:0]    cnt_q, cnt_d;
  logic [CntBits-1:0]    idx_q, idx_d;
  logic [IdBits-1:0]     hit_id_q;
  logic [HandleBits-1:0] hit_hnd_q;

  logic                  we;
  logic [AddrBits-1:0]   waddr, raddr;
  logic [IdBits-1:0]     wid, rid;
  logic [HandleBits-1:0] whnd, rhnd;
  logic [CntBits-1:0]    rd_idx;

  logic [HandleBits-1:0] req_hnd;
  always_comb begin
    req_hnd = '0;
    for (int b = 0; b < HandleBits && b < OutHandleBits; b++) begin
      req_hnd[b] = req_i.entry_handle[b];
    end
  end

  // Read address: entry next to idx for shifts, else idx itself
  always_comb begin
    rd_idx = idx_q;
    if (cmd_i.shift_up || cmd_i.peek_dn) rd_idx = idx_q - CntBits'(1);
    if (cmd_i.shift_dn || cmd_i.peek_up) rd_idx = idx_q + CntBits'(1);
    raddr = rd_idx[AddrBits-1:0];
  end

  // Write: shifted entry or new entry at idx
  always_comb begin
    we    = cmd_i.shift_up | cmd_i.shift_dn | cmd_i.write_new;
    waddr = idx_q[AddrBits-1:0];
    wid   = cmd_i.write_new ? key_q : rid;
    whnd  = cmd_i.write_new ? hnd_q : rhnd;
  end

  sise_ram #(.Width(IdBits), .Depth(Capacity)) u_id_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wid), .raddr_i(raddr), .rdata_o(rid)
  );
  sise_ram #(.Width(HandleBits), .Depth(Capacity)) u_hnd_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(whnd), .raddr_i(raddr),
    .rdata_o(rhnd)
  );

  // Compare results on the registered read data
  always_comb begin
    stat_o.scan_end   = (idx_q == cnt_q);
    stat_o.id_hit     = rd_valid_i && (rid == key_q);
    stat_o.id_greater = rd_valid_i && (rid > key_q);
    stat_o.hnd_hit    = rd_valid_i && (rhnd == hnd_q);
    stat_o.full       = (cnt_q == CntBits'(Capacity));
    stat_o.empty      = (cnt_q == '0);
    stat_o.at_bottom  = (idx_q == '0);
    stat_o.drop_end   = (idx_q + CntBits'(1) >= cnt_q);
  end

  // Index and count update
  always_comb begin
    idx_d = idx_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      idx_d = '0;
    end else if (cmd_i.to_top) begin
      idx_d = cnt_q;
    end else if (cmd_i.scan || cmd_i.shift_dn) begin
      idx_d = idx_q + CntBits'(1);
    end else if (cmd_i.shift_up) begin
      idx_d = idx_q - CntBits'(1);
    end
    if (cmd_i.write_new) cnt_d = cnt_q + CntBits'(1);
    if (cmd_i.clear) cnt_d = '0;
    else if (rsp_kind_i == 2'd1 && cmd_i.respond && op_q != OP_LOOKUP
             && op_q != OP_INSERT) cnt_d = cnt_q - CntBits'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  // Request and hit capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= req_i.operation;
      key_q <= req_i.key_id;
      hnd_q <= req_hnd;
    end
    if (rsp_found_i) begin
      hit_id_q  <= rid;
      hit_hnd_q <= rhnd;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.respond) begin
      rsp_o.found         <= (rsp_kind_i == 2'd1);
      rsp_o.result_id     <= (rsp_kind_i == 2'd1) ? hit_id_q : '0;
      rsp_o.result_handle <= (rsp_kind_i == 2'd1) ? OutHandleBits'(hit_hnd_q) : '0;
      rsp_o.status        <= rsp_miss_i ? ST_NOTFOUND :
                             (rsp_kind_i == 2'd2) ? ST_FULL : ST_DONE;
      rsp_o.entry_count   <= CountBits'(cnt_d);
      rsp_o.is_empty      <= (cnt_d == '0);
    end
  end
endmodule
`default_nettype wire

/* rtl/sise_ctrl.sv */
// Controller of the sorted id set engine: sequences scans, shifts and
// the result strobe. Depends on sise_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sise_ctrl import sise_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start_i,
  input  wire logic [2:0] op_i,
  input  wire stat_t stat_i,
  output logic       busy_o,
  output cmd_t       cmd_o,
  output logic       rd_valid_o,
  output logic [1:0] rsp_kind_o,
  output logic       rsp_found_o,
  output logic       rsp_miss_o,
  output logic       done_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SCAN_WAIT, S_INS_SHIFT, S_DROP, S_DONE
  } state_e;

  state_e     state_q;
  logic [2:0] op_q;
  logic       wait_q;   // read data not yet valid
  logic       found_q;
  logic       full_q;
  logic       done_q;

  // Drive commands from the current state
  always_comb begin
    cmd_o       = '0;
    rsp_found_o = 1'b0;
    rsp_kind_o  = 2'd0;
    rsp_miss_o  = 1'b0;
    rd_valid_o  = (state_q == S_SCAN_WAIT);
    case (state_q)
      S_IDLE: cmd_o.load = start_i;
      S_SCAN: ; // issue read at idx
      S_SCAN_WAIT: begin
        if (!stat_i.scan_end) begin
          if (op_q == OP_POP) begin
            rsp_found_o = 1'b1;
          end else if (op_q == OP_REMOVE) begin
            if (stat_i.hnd_hit) rsp_found_o = 1'b1;
            else cmd_o.scan = 1'b1;
          end else if (stat_i.id_hit) begin
            rsp_found_o = 1'b1;
          end else if (!stat_i.id_greater) begin
            cmd_o.scan = 1'b1;
          end
        end
        // New id to insert: shift down from the top of the set
        if (op_q == OP_INSERT && !rsp_found_o && !cmd_o.scan && !stat_i.full) begin
          cmd_o.to_top = 1'b1;
        end
      end
      S_INS_SHIFT: begin
        if (!wait_q) begin
          if (!stat_i.at_bottom && stat_i.id_greater) cmd_o.shift_up = 1'b1;
          else cmd_o.write_new = 1'b1;
        end else begin
          cmd_o.peek_dn = 1'b1;
        end
      end
      S_DROP: begin
        if (wait_q) cmd_o.peek_up = 1'b1;
        else if (!stat_i.drop_end) cmd_o.shift_dn = 1'b1;
      end
      S_DONE: begin
        cmd_o.respond = 1'b1;
        cmd_o.clear   = (op_q == OP_CLEAR);
        rsp_kind_o    = found_q ? 2'd1 : full_q ? 2'd2 : 2'd0;
        rsp_miss_o    = !found_q && !full_q && (op_q == OP_LOOKUP ||
                        op_q == OP_REMOVE || op_q == OP_POP);
      end
      default: ;
    endcase
  end

  // rd_valid in INS_SHIFT is given by the busy term at the top level
  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  // State and registered flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_LOOKUP;
      wait_q  <= 1'b0;
      found_q <= 1'b0;
      full_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_o.respond;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            op_q    <= op_i;
            found_q <= 1'b0;
            full_q  <= 1'b0;
            case (op_i)
              OP_LOOKUP, OP_REMOVE, OP_INSERT: state_q <= S_SCAN;
              OP_POP:   state_q <= S_SCAN;
              default:  state_q <= S_DONE;
            endcase
          end
        end
        S_SCAN: state_q <= S_SCAN_WAIT;
        S_SCAN_WAIT: begin
          if (rsp_found_o) begin
            found_q <= (op_q != OP_POP) || 1'b1;
            if (op_q == OP_REMOVE || op_q == OP_POP) state_q <= S_DROP;
            else state_q <= S_DONE;
            wait_q <= 1'b1;
          end else if (op_q == OP_POP) begin
            if (stat_i.empty) state_q <= S_DONE;
            else begin
              found_q <= 1'b1;
              state_q <= S_DROP;
              wait_q  <= 1'b1;
            end
          end else if (cmd_o.scan) begin
            state_q <= S_SCAN;
          end else if (op_q == OP_INSERT) begin
            if (stat_i.full) begin
              full_q  <= 1'b1;
              state_q <= S_DONE;
            end else begin
              state_q <= S_INS_SHIFT;
              wait_q  <= 1'b1;
            end
          end else begin
            state_q <= S_DONE;
          end
        end
        S_INS_SHIFT: begin
          wait_q <= !wait_q;
          if (cmd_o.write_new) begin
            state_q <= S_DONE;
            wait_q  <= 1'b0;
          end
        end
        S_DROP: begin
          wait_q <= 1'b0;
          if (!wait_q) begin
            if (stat_i.drop_end) state_q <= S_DONE;
            else wait_q <= 1'b1;
          end
        end
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/sorted_id_set_engine.sv */
// Top level of the sorted id set engine: controller plus datapath.
// Depends on sise_pkg, sise_ctrl, sise_datapath.
`timescale 1ns / 1ps
`default_nettype none
// A request is taken when start_i is high and busy_o low; its single
// result appears with done_o for one cycle and must be taken then, the
// receiver cannot stall. Entries live in memories walked by one index
// with a registered read, so each step issues a read and then waits for
// its data: entries are scanned for lookup, insert and remove, shifted
// on insert and moved on remove and pop. Clear and the unused codes go
// straight to the result state without a scan, and busy_o drops in the
// result cycle.
module sorted_id_set_engine import sise_pkg::*; #(
  parameter int unsigned CAPACITY    = 128,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire req_t req_i,
  output logic      busy_o,
  output logic      done_o,
  output rsp_t      rsp_o
);
  cmd_t       cmd;
  stat_t      stat;
  logic       rd_valid, rsp_found, rsp_miss;
  logic [1:0] rsp_kind;

  sise_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .op_i(req_i.operation), .stat_i(stat),
    .busy_o, .cmd_o(cmd), .rd_valid_o(rd_valid), .rsp_kind_o(rsp_kind),
    .rsp_found_o(rsp_found), .rsp_miss_o(rsp_miss), .done_o
  );

  sise_datapath #(.Capacity(CAPACITY), .HandleBits(HANDLE_BITS)) u_dp (
    .clk_i, .rst_ni, .req_i, .cmd_i(cmd), .rd_valid_i(rd_valid | cmd.shift_up |
    cmd.write_new | cmd.shift_dn | (busy_o & ~cmd.respond & ~cmd.load)),
    .rsp_kind_i(rsp_kind), .rsp_found_i(rsp_found), .rsp_miss_i(rsp_miss),
    .stat_o(stat), .rsp_o
  );
endmodule
`default_nettype wire

/* rtl/sise_checker.sv */
// Port-level checker for the sorted id set engine, bound to the top.
// Depends on sise_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sise_checker import sise_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_o,
  input wire logic done_o,
  input wire rsp_t rsp_o
);
  // Accepted request makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("busy not raised");
  // Result strobe is a single pulse
  a_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  // Empty flag agrees with count
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.is_empty == (rsp_o.entry_count == '0)))
    else $error("empty mismatch");
  // Found results carry done status
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.found |-> rsp_o.status == ST_DONE) else $error("found status");
endmodule

bind sorted_id_set_engine sise_checker u_chk (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .rsp_o
);
`default_nettype wire
